FILE: sv/adsr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the exponential ADSR envelope.
// No dependencies; the multiplier, divider and envelope core import this package.
package adsr_pkg;

    // digit-serial multiplier: operand width, digit width, product width
    localparam int MW  = 36;
    localparam int DGW = 4;
    localparam int PW  = 2 * MW;
    // dividend width of the serial divider (Q4.32 log value)
    localparam int DDW = 36;

    localparam logic [2:0] STG_IDLE    = 3'd0;
    localparam logic [2:0] STG_ATTACK  = 3'd1;
    localparam logic [2:0] STG_DECAY   = 3'd2;
    localparam logic [2:0] STG_SUSTAIN = 3'd3;
    localparam logic [2:0] STG_RELEASE = 3'd4;

    localparam logic [2:0] CFG_ATT_TIME = 3'd0;
    localparam logic [2:0] CFG_ATT_AMT  = 3'd1;
    localparam logic [2:0] CFG_DEC_TIME = 3'd2;
    localparam logic [2:0] CFG_DEC_AMT  = 3'd3;
    localparam logic [2:0] CFG_SUS_LVL  = 3'd4;
    localparam logic [2:0] CFG_SUS_AMT  = 3'd5;
    localparam logic [2:0] CFG_REL_TIME = 3'd6;
    localparam logic [2:0] CFG_REL_AMT  = 3'd7;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [18:0] ATT_TGT_Q16 = 19'd78643;
    localparam logic [18:0] EPS_Q16     = 19'd66;
    localparam logic [25:0] A_ATTACK    = 26'd393216;
    localparam logic [25:0] A_RELEASE   = 26'd65601536;
    localparam logic [31:0] LN2_Q32     = 32'hB17217F8;
    localparam logic [3:0]  TAYLOR_LAST = 4'd13;

    function automatic logic [17:0] f_mag18(input logic [17:0] x);
        return x[17] ? (~x + 18'd1) : x;
    endfunction

    // base + floor(mod*amt / 2^16), clamped to [0, 1.0]
    function automatic logic [16:0] f_modulate(input logic [16:0] base,
                                               input logic [MW-1:0] pmag,
                                               input logic neg);
        logic signed [39:0] p;
        logic signed [39:0] v;
        p = signed'(40'(pmag));
        if (neg) p = -p;
        v = (p >>> 16) + signed'(40'(base));
        if (v < 0) return 17'd0;
        else if (v > signed'(40'(ONE_Q16))) return ONE_Q16;
        else return v[16:0];
    endfunction

endpackage

FILE: sv/adsr_if.sv
`timescale 1ns / 1ps
// Channel interfaces: sample tick in, envelope beat out.
// No dependencies.
interface adsr_smp_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] attack_mod;
    logic signed [17:0] decay_mod;
    logic signed [17:0] sustain_mod;
    logic signed [17:0] release_mod;
    logic               gate;
    logic               retrigger;
    modport source(output valid, attack_mod, decay_mod, sustain_mod, release_mod,
                   gate, retrigger, input ready);
    modport sink(input valid, attack_mod, decay_mod, sustain_mod, release_mod,
                 gate, retrigger, output ready);
endinterface

interface adsr_env_if;
    logic        valid;
    logic        ready;
    logic [16:0] level;
    logic [2:0]  stage;
    modport source(output valid, level, stage, input ready);
    modport sink(input valid, level, stage, output ready);
endinterface

FILE: sv/adsr_mul.sv
`timescale 1ns / 1ps
// Digit-serial unsigned multiplier, DGW multiplier bits per cycle.
// Depends on adsr_pkg.
module adsr_mul import adsr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic          o_done,
    output logic [PW-1:0] o_prod
);
    localparam int NDIG = (MW + DGW - 1) / DGW;
    localparam int CW   = $clog2(NDIG + 1);

    logic [MW-1:0]     r_a;
    logic [MW-1:0]     r_b;
    logic [PW-1:0]     r_acc;
    logic [PW-1:0]     n_acc;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MW+DGW-1:0] part;
    logic [MW+DGW:0]   top_sum;

    // partial product enters at the top, accumulator slides right one digit
    always_comb begin
        part    = (MW+DGW)'(r_a) * (MW+DGW)'(r_b[DGW-1:0]);
        top_sum = (MW+DGW+1)'(r_acc[PW-1:MW]) + (MW+DGW+1)'(part);
        n_acc   = PW'({top_sum, r_acc[MW-1:0]} >> DGW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NDIG);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b >> DGW;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

FILE: sv/adsr_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on adsr_pkg.
module adsr_div import adsr_pkg::*; #(
    parameter int DVW = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DDW-1:0] i_num,
    input  logic [DVW-1:0] i_den,
    output logic           o_done,
    output logic [DDW-1:0] o_quot
);
    localparam int CW = $clog2(DDW + 1);

    logic [DDW-1:0] r_q;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   rem2;
    logic           ge;
    logic [DVW:0]   n_rem;

    always_comb begin
        rem2  = {r_rem, r_q[DDW-1]};
        ge    = (rem2 >= {1'b0, r_den});
        n_rem = ge ? (rem2 - {1'b0, r_den}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DDW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DDW-2:0], ge};
            r_rem <= n_rem[DVW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: sv/exponential_adsr_envelope_core.sv
`timescale 1ns / 1ps
// Exponential ADSR envelope core; one beat in, one envelope beat out.
// Idle, sustain and zero-length beats skip the log and Taylor steps; a curve beat
// runs 32 squarings on the digit-serial multiplier for the log, then 14
// bit-serial divides for e and the Taylor terms. One beat at a time; a
// finished beat waits in the output register. Synchronous active-low reset
// clears config, stage and history.
module exponential_adsr_envelope_core import adsr_pkg::*; #(
    parameter int SAMPLE_RATE = 48000,
    parameter int MAX_SECONDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data,
    adsr_smp_if.sink    i_smp,
    adsr_env_if.source  o_env
);
    localparam int KSM = SAMPLE_RATE * MAX_SECONDS;
    localparam int NW  = $clog2(KSM + 1);

    localparam logic [4:0] F_IDLE   = 5'd0;
    localparam logic [4:0] F_MODS   = 5'd1;
    localparam logic [4:0] F_MODS_W = 5'd2;
    localparam logic [4:0] F_MODT   = 5'd3;
    localparam logic [4:0] F_MODT_W = 5'd4;
    localparam logic [4:0] F_NMUL   = 5'd5;
    localparam logic [4:0] F_NMUL_W = 5'd6;
    localparam logic [4:0] F_PREP   = 5'd7;
    localparam logic [4:0] F_NORM   = 5'd8;
    localparam logic [4:0] F_SQ     = 5'd9;
    localparam logic [4:0] F_SQ_W   = 5'd10;
    localparam logic [4:0] F_DIV    = 5'd11;
    localparam logic [4:0] F_DIV_W  = 5'd12;
    localparam logic [4:0] F_ZMUL   = 5'd13;
    localparam logic [4:0] F_ZMUL_W = 5'd14;
    localparam logic [4:0] F_TMUL   = 5'd15;
    localparam logic [4:0] F_TMUL_W = 5'd16;
    localparam logic [4:0] F_TDIV   = 5'd17;
    localparam logic [4:0] F_TDIV_W = 5'd18;
    localparam logic [4:0] F_COEF   = 5'd19;
    localparam logic [4:0] F_AMUL   = 5'd20;
    localparam logic [4:0] F_AMUL_W = 5'd21;
    localparam logic [4:0] F_DONE   = 5'd22;

    // configuration
    logic [16:0] r_att_time, r_dec_time, r_sus_lvl, r_rel_time;
    logic [17:0] r_att_amt, r_dec_amt, r_sus_amt, r_rel_amt;

    // envelope state
    logic [2:0]  r_stage;
    logic [16:0] r_level;
    logic [16:0] r_sus_last;
    logic        r_gate;
    logic        r_retr;

    // per-beat working registers
    logic [4:0]         r_fsm;
    logic [2:0]         r_st;
    logic               r_gin, r_rin;
    logic [17:0]        r_smod;
    logic [17:0]        r_tmod;
    logic [17:0]        r_tamt;
    logic [16:0]        r_tbase;
    logic [16:0]        r_tv;
    logic [16:0]        r_sus;
    logic [NW-1:0]      r_n;
    logic [31:0]        r_m;
    logic [3:0]         r_int;
    logic [31:0]        r_frac;
    logic [4:0]         r_sq_cnt;
    logic [DDW-1:0]     r_e;
    logic [31:0]        r_z;
    logic [32:0]        r_term;
    logic signed [34:0] r_sum;
    logic [3:0]         r_j;
    logic [31:0]        r_c;
    logic signed [18:0] r_tgt;
    logic               r_dneg;
    logic [16:0]        r_mag;
    logic [16:0]        r_lvl;

    logic        r_out_valid;
    logic [16:0] r_out_level;
    logic [2:0]  r_out_stage;

    // shared units
    logic           mul_start;
    logic [MW-1:0]  mul_a, mul_b;
    logic           mul_done;
    logic [PW-1:0]  mul_prod;
    logic           div_start;
    logic [DDW-1:0] div_num;
    logic [NW-1:0]  div_den;
    logic           div_done;
    logic [DDW-1:0] div_quot;

    adsr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    adsr_div #(.DVW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next stage from history and gate/retrigger edges
    logic [2:0] st_next;
    logic       rise, fall;
    always_comb begin
        unique case (r_stage)
            STG_ATTACK:  st_next = (r_level == ONE_Q16) ? STG_DECAY : STG_ATTACK;
            STG_DECAY:   st_next = (r_level == r_sus_last) ? STG_SUSTAIN : STG_DECAY;
            STG_SUSTAIN: st_next = STG_SUSTAIN;
            STG_RELEASE: st_next = (r_level == 17'd0) ? STG_IDLE : STG_RELEASE;
            default:     st_next = STG_IDLE;
        endcase
        rise = (!r_gate && i_smp.gate) || (!r_retr && i_smp.retrigger);
        fall = r_gate && !i_smp.gate;
        if (rise) st_next = STG_ATTACK;
        if (fall) st_next = STG_RELEASE;
    end

    logic accept;
    assign accept      = i_smp.valid && (r_fsm == F_IDLE);
    assign i_smp.ready = (r_fsm == F_IDLE);

    // operand select for the multiplier and divider
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = {r_int, r_frac};
        div_den   = r_n;
        unique case (r_fsm)
            F_MODS: begin
                mul_start = 1'b1;
                mul_a     = MW'(f_mag18(r_smod));
                mul_b     = MW'(f_mag18(r_sus_amt));
            end
            F_MODT: begin
                mul_start = 1'b1;
                mul_a     = MW'(f_mag18(r_tmod));
                mul_b     = MW'(f_mag18(r_tamt));
            end
            F_NMUL: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_tv);
                mul_b     = MW'(KSM);
            end
            F_SQ: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_m);
                mul_b     = MW'(r_m);
            end
            F_ZMUL: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_e[31:0]);
                mul_b     = MW'(LN2_Q32);
            end
            F_TMUL: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_term);
                mul_b     = MW'(r_z);
            end
            F_AMUL: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_mag);
                mul_b     = MW'(r_c);
            end
            F_DIV: begin
                div_start = 1'b1;
            end
            F_TDIV: begin
                div_start = 1'b1;
                div_num   = DDW'(r_term);
                div_den   = NW'(r_j);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // datapath helpers
    logic [16:0]        sus_val, t_val;
    logic [32:0]        sq;
    logic [32:0]        term_q;
    logic [25:0]        a_dec;
    logic [33:0]        sum_pos;
    logic [33:0]        c_sh;
    logic signed [18:0] tgt;
    logic signed [18:0] dlt;
    logic [16:0]        nm;
    logic signed [18:0] appr;
    logic [16:0]        appr_lvl;

    always_comb begin
        sus_val = f_modulate(r_sus_lvl, mul_prod[MW-1:0], r_smod[17] ^ r_sus_amt[17]);
        t_val   = f_modulate(r_tbase, mul_prod[MW-1:0], r_tmod[17] ^ r_tamt[17]);
        sq      = mul_prod[63:31];
        term_q  = div_quot[32:0];
        a_dec   = 26'd65536 + 26'(ONE_Q16 - r_sus) * 26'd1000;
        sum_pos = r_sum[34] ? 34'd0 : r_sum[33:0];
        c_sh    = sum_pos >> r_e[35:32];
        unique case (r_st)
            STG_ATTACK: tgt = signed'(ATT_TGT_Q16);
            STG_DECAY:  tgt = signed'({2'b00, r_sus}) - signed'(EPS_Q16);
            default:    tgt = -signed'(EPS_Q16);
        endcase
        dlt  = signed'({2'b00, r_level}) - tgt;
        nm   = mul_prod[48:32];
        appr = r_dneg ? (r_tgt - signed'({2'b00, nm})) : (r_tgt + signed'({2'b00, nm}));
        // clamp at the segment end, then to [0, 1.0]
        if (r_st == STG_ATTACK && appr > signed'({2'b00, ONE_Q16}))
            appr = signed'({2'b00, ONE_Q16});
        if (r_st == STG_DECAY && appr < signed'({2'b00, r_sus}))
            appr = signed'({2'b00, r_sus});
        if (appr < 0)
            appr_lvl = 17'd0;
        else if (appr > signed'({2'b00, ONE_Q16}))
            appr_lvl = ONE_Q16;
        else
            appr_lvl = appr[16:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_time <= '0;
            r_att_amt  <= '0;
            r_dec_time <= '0;
            r_dec_amt  <= '0;
            r_sus_lvl  <= '0;
            r_sus_amt  <= '0;
            r_rel_time <= '0;
            r_rel_amt  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATT_TIME: r_att_time <= i_cfg_data[16:0];
                CFG_ATT_AMT:  r_att_amt  <= i_cfg_data;
                CFG_DEC_TIME: r_dec_time <= i_cfg_data[16:0];
                CFG_DEC_AMT:  r_dec_amt  <= i_cfg_data;
                CFG_SUS_LVL:  r_sus_lvl  <= i_cfg_data[16:0];
                CFG_SUS_AMT:  r_sus_amt  <= i_cfg_data;
                CFG_REL_TIME: r_rel_time <= i_cfg_data[16:0];
                CFG_REL_AMT:  r_rel_amt  <= i_cfg_data;
                default:      r_rel_amt  <= r_rel_amt;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= F_IDLE;
            r_stage     <= STG_IDLE;
            r_level     <= '0;
            r_sus_last  <= '0;
            r_gate      <= 1'b0;
            r_retr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in F_DONE the output register is either kept or reloaded below
            if (o_env.ready && r_fsm != F_DONE) r_out_valid <= 1'b0;
            unique case (r_fsm)
                F_IDLE:   if (accept) r_fsm <= F_MODS;
                F_MODS:   r_fsm <= F_MODS_W;
                F_MODS_W: begin
                    if (mul_done) begin
                        if (r_st == STG_ATTACK || r_st == STG_DECAY || r_st == STG_RELEASE)
                            r_fsm <= F_MODT;
                        else
                            r_fsm <= F_DONE;
                    end
                end
                F_MODT:   r_fsm <= F_MODT_W;
                F_MODT_W: if (mul_done) r_fsm <= F_NMUL;
                F_NMUL:   r_fsm <= F_NMUL_W;
                F_NMUL_W: if (mul_done) r_fsm <= F_PREP;
                F_PREP:   r_fsm <= (r_n == '0) ? F_DONE : F_NORM;
                F_NORM:   if (r_m[31]) r_fsm <= F_SQ;
                F_SQ:     r_fsm <= F_SQ_W;
                F_SQ_W:   if (mul_done) r_fsm <= (r_sq_cnt == 5'd31) ? F_DIV : F_SQ;
                F_DIV:    r_fsm <= F_DIV_W;
                F_DIV_W:  if (div_done) r_fsm <= F_ZMUL;
                F_ZMUL:   r_fsm <= F_ZMUL_W;
                F_ZMUL_W: if (mul_done) r_fsm <= F_TMUL;
                F_TMUL:   r_fsm <= F_TMUL_W;
                F_TMUL_W: if (mul_done) r_fsm <= F_TDIV;
                F_TDIV:   r_fsm <= F_TDIV_W;
                F_TDIV_W: if (div_done) r_fsm <= (r_j == TAYLOR_LAST) ? F_COEF : F_TMUL;
                F_COEF:   r_fsm <= F_AMUL;
                F_AMUL:   r_fsm <= F_AMUL_W;
                F_AMUL_W: if (mul_done) r_fsm <= F_DONE;
                F_DONE: begin
                    if (!r_out_valid || o_env.ready) begin
                        r_out_valid <= 1'b1;
                        r_stage     <= r_st;
                        r_level     <= r_lvl;
                        r_sus_last  <= r_sus;
                        r_gate      <= r_gin;
                        r_retr      <= r_rin;
                        r_fsm       <= F_IDLE;
                    end
                end
                default:  r_fsm <= F_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_fsm)
            F_IDLE: begin
                if (accept) begin
                    r_st   <= st_next;
                    r_gin  <= i_smp.gate;
                    r_rin  <= i_smp.retrigger;
                    r_smod <= i_smp.sustain_mod;
                    unique case (st_next)
                        STG_ATTACK: begin
                            r_tbase <= r_att_time;
                            r_tamt  <= r_att_amt;
                            r_tmod  <= i_smp.attack_mod;
                        end
                        STG_RELEASE: begin
                            r_tbase <= r_rel_time;
                            r_tamt  <= r_rel_amt;
                            r_tmod  <= i_smp.release_mod;
                        end
                        default: begin
                            r_tbase <= r_dec_time;
                            r_tamt  <= r_dec_amt;
                            r_tmod  <= i_smp.decay_mod;
                        end
                    endcase
                end
            end
            F_MODS_W: begin
                if (mul_done) begin
                    r_sus <= sus_val;
                    r_lvl <= (r_st == STG_SUSTAIN) ? sus_val : 17'd0;
                end
            end
            F_MODT_W: if (mul_done) r_tv <= t_val;
            F_NMUL_W: if (mul_done) r_n <= mul_prod[NW+15:16];
            F_PREP: begin
                // zero length: jump straight to the segment end
                unique case (r_st)
                    STG_ATTACK: begin
                        r_lvl <= ONE_Q16;
                        r_m   <= 32'(A_ATTACK);
                    end
                    STG_DECAY: begin
                        r_lvl <= r_sus;
                        r_m   <= 32'(a_dec);
                    end
                    default: begin
                        r_lvl <= 17'd0;
                        r_m   <= 32'(A_RELEASE);
                    end
                endcase
                r_int    <= 4'd15;
                r_sq_cnt <= 5'd0;
            end
            F_NORM: begin
                if (!r_m[31]) begin
                    r_m   <= {r_m[30:0], 1'b0};
                    r_int <= r_int - 4'd1;
                end
            end
            F_SQ_W: begin
                if (mul_done) begin
                    r_m      <= sq[32] ? sq[32:1] : sq[31:0];
                    r_frac   <= {r_frac[30:0], sq[32]};
                    r_sq_cnt <= r_sq_cnt + 5'd1;
                end
            end
            F_DIV_W: if (div_done) r_e <= div_quot;
            F_ZMUL_W: begin
                if (mul_done) begin
                    r_z    <= mul_prod[63:32];
                    r_term <= 33'h1_0000_0000;
                    r_sum  <= 35'sh1_0000_0000;
                    r_j    <= 4'd1;
                end
            end
            F_TMUL_W: if (mul_done) r_term <= mul_prod[64:32];
            F_TDIV_W: begin
                if (div_done) begin
                    r_term <= term_q;
                    r_sum  <= r_j[0] ? (r_sum - signed'({2'b00, term_q}))
                                     : (r_sum + signed'({2'b00, term_q}));
                    r_j    <= r_j + 4'd1;
                end
            end
            F_COEF: begin
                r_c    <= (c_sh > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : c_sh[31:0];
                r_tgt  <= tgt;
                r_dneg <= dlt[18];
                r_mag  <= dlt[18] ? 17'(-dlt) : dlt[16:0];
            end
            F_AMUL_W: if (mul_done) r_lvl <= appr_lvl;
            default: r_lvl <= r_lvl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == F_DONE && (!r_out_valid || o_env.ready)) begin
            r_out_level <= r_lvl;
            r_out_stage <= r_st;
        end
    end

    assign o_env.valid = r_out_valid;
    assign o_env.level = r_out_level;
    assign o_env.stage = r_out_stage;
endmodule
